/* hdl/avr_pkg.sv */
// Shared types, constants and the arctangent table for the axis-angle view rotation.
// Depends on nothing; the CORDIC cell, the matrix and the top level use it by scoped names.
`timescale 1ns / 1ps

package avr_pkg;

   // CORDIC datapath widths (Q3.30 for x and y, residual angle in Q2.30)
   localparam int CW = 34;
   localparam int ZW = 33;

   // Angle fold points in Q3.13 and CORDIC start gain in Q3.30
   localparam logic signed [16:0] PI_Q13      = 17'sd25736;
   localparam logic signed [16:0] HALF_PI_Q13 = 17'sd12868;
   localparam logic signed [CW-1:0] GAIN_Q30  = 34'sd652032874;
   localparam logic signed [35:0] ONE_Q30     = 36'sd1073741824;

   typedef logic signed [CW-1:0] cw_type;
   typedef logic signed [ZW-1:0] zw_type;

   // Payload that travels beside the CORDIC along the chain
   typedef struct packed {
      logic signed [32:0] dx;
      logic signed [32:0] dy;
      logic signed [32:0] dz;
      logic signed [31:0] ex;
      logic signed [31:0] ey;
      logic signed [31:0] ez;
      logic signed [15:0] ax;
      logic signed [15:0] ay;
      logic signed [15:0] az;
      logic signed [31:0] pxx;
      logic signed [31:0] pxy;
      logic signed [31:0] pxz;
      logic signed [31:0] pyy;
      logic signed [31:0] pyz;
      logic signed [31:0] pzz;
      logic               neg;
   } item_type;

   // Arctangent of 2^-i in Q2.30
   function automatic logic [29:0] atan_q30(input int unsigned idx);
      logic [29:0] v;
      case (idx)
         0:  v = 30'd843314857;
         1:  v = 30'd497837829;
         2:  v = 30'd263043837;
         3:  v = 30'd133525159;
         4:  v = 30'd67021687;
         5:  v = 30'd33543516;
         6:  v = 30'd16775851;
         7:  v = 30'd8388437;
         8:  v = 30'd4194283;
         9:  v = 30'd2097149;
         10: v = 30'd1048576;
         11: v = 30'd524288;
         12: v = 30'd262144;
         13: v = 30'd131072;
         14: v = 30'd65536;
         15: v = 30'd32768;
         16: v = 30'd16384;
         17: v = 30'd8192;
         18: v = 30'd4096;
         19: v = 30'd2048;
         20: v = 30'd1024;
         21: v = 30'd512;
         22: v = 30'd256;
         23: v = 30'd128;
         default: v = 30'd0;
      endcase
      return v;
   endfunction

endpackage

/* hdl/avr_cordic_cell.sv */
// One rotation-mode CORDIC micro-rotation with its passenger payload.
// Depends on avr_pkg.
`timescale 1ns / 1ps

module avr_cordic_cell #(
   parameter int STEP = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              valid_i,
   input  avr_pkg::cw_type   x_i,
   input  avr_pkg::cw_type   y_i,
   input  avr_pkg::zw_type   z_i,
   input  avr_pkg::item_type item_i,
   output logic              valid_o,
   output avr_pkg::cw_type   x_o,
   output avr_pkg::cw_type   y_o,
   output avr_pkg::zw_type   z_o,
   output avr_pkg::item_type item_o
);

   localparam logic signed [avr_pkg::ZW-1:0] ATAN =
      avr_pkg::ZW'($signed({1'b0, avr_pkg::atan_q30(STEP)}));

   logic              valid_ff;
   avr_pkg::cw_type   x_ff, x_in;
   avr_pkg::cw_type   y_ff, y_in;
   avr_pkg::zw_type   z_ff, z_in;
   avr_pkg::item_type item_ff;

   // Rotate towards zero residual angle
   always_comb begin
      if (!z_i[avr_pkg::ZW-1]) begin
         x_in = x_i - (y_i >>> STEP);
         y_in = y_i + (x_i >>> STEP);
         z_in = z_i - ATAN;
      end else begin
         x_in = x_i + (y_i >>> STEP);
         y_in = y_i - (x_i >>> STEP);
         z_in = z_i + ATAN;
      end
   end

   // Hold the valid flag under reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_i;
      end
   end

   // Advance the datapath
   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      item_ff <= item_i;
   end

   assign valid_o = valid_ff;
   assign x_o     = x_ff;
   assign y_o     = y_ff;
   assign z_o     = z_ff;
   assign item_o  = item_ff;

endmodule

/* hdl/avr_matrix.sv */
// Builds the nine Rodrigues matrix entries in Q24 from cosine, sine and axis products.
// Two stages: partial products, then recombine, round and sum. Depends on avr_pkg.
`timescale 1ns / 1ps

module avr_matrix (
   input  logic               clock,
   input  logic               reset,
   input  logic               valid_i,
   input  avr_pkg::cw_type    x_i,
   input  avr_pkg::cw_type    y_i,
   input  avr_pkg::item_type  item_i,
   output logic               valid_o,
   output logic signed [31:0] mat_o [9],
   output logic signed [32:0] d_o [3],
   output logic signed [31:0] e_o [3]
);

   logic signed [35:0] t;
   logic signed [33:0] c;
   logic signed [33:0] s;
   logic signed [31:0] prod [6];

   logic               v1_ff, v2_ff;
   logic signed [52:0] tl_ff [6];
   logic signed [51:0] th_ff [6];
   logic signed [49:0] sa_ff [3];
   logic signed [33:0] c_ff;
   logic signed [32:0] d1_ff [3];
   logic signed [31:0] e1_ff [3];

   logic signed [31:0] tr [6];
   logic signed [31:0] sr [3];
   logic signed [31:0] ct;
   logic signed [67:0] full [6];
   logic signed [31:0] mat_ff [9], mat_in [9];
   logic signed [32:0] d2_ff [3];
   logic signed [31:0] e2_ff [3];

   // Apply the quadrant fold sign, form t = 1 - c
   always_comb begin
      c = item_i.neg ? -x_i : x_i;
      s = item_i.neg ? -y_i : y_i;
      t = avr_pkg::ONE_Q30 - 36'(c);
      prod[0] = item_i.pxx;
      prod[1] = item_i.pxy;
      prod[2] = item_i.pxz;
      prod[3] = item_i.pyy;
      prod[4] = item_i.pyz;
      prod[5] = item_i.pzz;
   end

   // Split each axis product into halves so each multiplier stays narrow
   always_ff @(posedge clock) begin
      for (int k = 0; k < 6; k++) begin
         tl_ff[k] <= 53'(t) * 53'($signed({1'b0, prod[k][15:0]}));
         th_ff[k] <= 52'(t) * 52'($signed(prod[k][31:16]));
      end
      sa_ff[0] <= 50'(s) * 50'(item_i.ax);
      sa_ff[1] <= 50'(s) * 50'(item_i.ay);
      sa_ff[2] <= 50'(s) * 50'(item_i.az);
      c_ff     <= c;
      d1_ff[0] <= item_i.dx;
      d1_ff[1] <= item_i.dy;
      d1_ff[2] <= item_i.dz;
      e1_ff[0] <= item_i.ex;
      e1_ff[1] <= item_i.ey;
      e1_ff[2] <= item_i.ez;
   end

   // Recombine halves and round every term on its own (half up)
   always_comb begin
      for (int k = 0; k < 6; k++) begin
         full[k] = (68'(th_ff[k]) <<< 16) + 68'(tl_ff[k]) + (68'sd1 <<< 33);
         tr[k]   = 32'(full[k] >>> 34);
      end
      for (int k = 0; k < 3; k++) begin
         sr[k] = 32'((sa_ff[k] + 50'sd524288) >>> 20);
      end
      ct = 32'((c_ff + 34'sd32) >>> 6);
      mat_in[0] = tr[0] + ct;
      mat_in[1] = tr[1] - sr[2];
      mat_in[2] = tr[2] + sr[1];
      mat_in[3] = tr[1] + sr[2];
      mat_in[4] = tr[3] + ct;
      mat_in[5] = tr[4] - sr[0];
      mat_in[6] = tr[2] - sr[1];
      mat_in[7] = tr[4] + sr[0];
      mat_in[8] = tr[5] + ct;
   end

   always_ff @(posedge clock) begin
      mat_ff <= mat_in;
      d2_ff  <= d1_ff;
      e2_ff  <= e1_ff;
   end

   // Hold valid flags under reset
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= valid_i;
         v2_ff <= v1_ff;
      end
   end

   assign valid_o = v2_ff;
   assign mat_o   = mat_ff;
   assign d_o     = d2_ff;
   assign e_o     = e2_ff;

endmodule

/* hdl/avr_apply.sv */
// Multiplies the matrix by the direction, rounds to Q16.16, adds the eye and saturates.
// Four stages ending in the output register. Depends on nothing outside this file.
`timescale 1ns / 1ps

module avr_apply (
   input  logic               clock,
   input  logic               reset,
   input  logic               valid_i,
   input  logic signed [31:0] mat_i [9],
   input  logic signed [32:0] d_i [3],
   input  logic signed [31:0] e_i [3],
   output logic               valid_o,
   output logic signed [31:0] res_o [3]
);

   logic [3:0]         v_ff;
   logic signed [48:0] lo_ff [9];
   logic signed [48:0] hi_ff [9];
   logic signed [65:0] ent_ff [9];
   logic signed [41:0] rnd_ff [3];
   logic signed [31:0] e1_ff [3], e2_ff [3], e3_ff [3];
   logic signed [31:0] res_ff [3], res_in [3];
   logic signed [65:0] acc [3];
   logic signed [42:0] sum [3];

   // Split each direction component into halves for narrow multipliers
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            lo_ff[3*i+j] <= 49'(mat_i[3*i+j]) * 49'($signed({1'b0, d_i[j][15:0]}));
            hi_ff[3*i+j] <= 49'(mat_i[3*i+j]) * 49'($signed(d_i[j][32:16]));
         end
      end
      e1_ff <= e_i;
   end

   // Recombine each entry product
   always_ff @(posedge clock) begin
      for (int k = 0; k < 9; k++) begin
         ent_ff[k] <= (66'(hi_ff[k]) <<< 16) + 66'(lo_ff[k]);
      end
      e2_ff <= e1_ff;
   end

   // Sum a row and round to Q16.16
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         acc[i] = ent_ff[3*i] + ent_ff[3*i+1] + ent_ff[3*i+2] + (66'sd1 <<< 23);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         rnd_ff[i] <= 42'(acc[i] >>> 24);
      end
      e3_ff <= e2_ff;
   end

   // Add the eye back and saturate
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sum[i] = 43'(e3_ff[i]) + 43'(rnd_ff[i]);
         if (sum[i] > 43'sd2147483647) begin
            res_in[i] = 32'sh7fffffff;
         end else if (sum[i] < -43'sd2147483648) begin
            res_in[i] = 32'sh80000000;
         end else begin
            res_in[i] = sum[i][31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   // Hold valid flags under reset
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[2:0], valid_i};
      end
   end

   assign valid_o = v_ff[3];
   assign res_o   = res_ff;

endmodule

/* hdl/axis_angle_view_rotate.sv */
// Top level of the axis-angle view rotation: front stage, CORDIC cell chain, matrix, apply.
// Depends on avr_pkg, avr_cordic_cell, avr_matrix and avr_apply.
//
// Usage:
//   A request is taken at each rising edge where start is high and busy is low.
//   busy is held low: a new request may enter every cycle.
//   Each request yields exactly one result, shown on the rsp_ ports for a single
//   cycle with rsp_valid high.
//   The path runs through the front stage (fold, direction, axis products), one CORDIC
//   cell per step, two matrix stages and four stages of matrix apply and saturate.
//   Throughput is one request per cycle; results leave in request order.
//   The receiver cannot stall: results are not held and must be taken when shown.
//   Synchronous reset drops every request in flight and clears rsp_valid; the
//   datapath registers carry no reset.
//   Results beyond the Q16.16 range saturate to the nearest bound.
`timescale 1ns / 1ps

module axis_angle_view_rotate #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_view_x,
   input  logic signed [31:0] req_view_y,
   input  logic signed [31:0] req_view_z,
   input  logic signed [31:0] req_eye_x,
   input  logic signed [31:0] req_eye_y,
   input  logic signed [31:0] req_eye_z,
   input  logic signed [15:0] req_axis_x,
   input  logic signed [15:0] req_axis_y,
   input  logic signed [15:0] req_axis_z,
   input  logic signed [15:0] req_turn_angle,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_new_view_x,
   output logic signed [31:0] rsp_new_view_y,
   output logic signed [31:0] rsp_new_view_z
);

   localparam int LAT = CORDIC_STEPS + 7;

   logic               accept;
   logic signed [16:0] ang;
   logic signed [16:0] ang_f;
   logic               neg;
   avr_pkg::item_type  item_in;

   logic               valid_s [CORDIC_STEPS+1];
   avr_pkg::cw_type    x_s     [CORDIC_STEPS+1];
   avr_pkg::cw_type    y_s     [CORDIC_STEPS+1];
   avr_pkg::zw_type    z_s     [CORDIC_STEPS+1];
   avr_pkg::item_type  item_s  [CORDIC_STEPS+1];

   logic               front_valid_ff;
   avr_pkg::zw_type    z_ff, z_in;
   avr_pkg::item_type  item_ff;

   logic               mat_valid;
   logic signed [31:0] mat [9];
   logic signed [32:0] dir [3];
   logic signed [31:0] eye [3];
   logic signed [31:0] res [3];

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Fold the angle into plus or minus pi/2, form direction and axis products
   always_comb begin
      ang = 17'(req_turn_angle);
      if (ang > avr_pkg::HALF_PI_Q13) begin
         ang_f = ang - avr_pkg::PI_Q13;
         neg   = 1'b1;
      end else if (ang < -avr_pkg::HALF_PI_Q13) begin
         ang_f = ang + avr_pkg::PI_Q13;
         neg   = 1'b1;
      end else begin
         ang_f = ang;
         neg   = 1'b0;
      end
      z_in        = {ang_f[15:0], 17'b0};
      item_in.dx  = 33'(req_view_x) - 33'(req_eye_x);
      item_in.dy  = 33'(req_view_y) - 33'(req_eye_y);
      item_in.dz  = 33'(req_view_z) - 33'(req_eye_z);
      item_in.ex  = req_eye_x;
      item_in.ey  = req_eye_y;
      item_in.ez  = req_eye_z;
      item_in.ax  = req_axis_x;
      item_in.ay  = req_axis_y;
      item_in.az  = req_axis_z;
      item_in.pxx = 32'(req_axis_x) * 32'(req_axis_x);
      item_in.pxy = 32'(req_axis_x) * 32'(req_axis_y);
      item_in.pxz = 32'(req_axis_x) * 32'(req_axis_z);
      item_in.pyy = 32'(req_axis_y) * 32'(req_axis_y);
      item_in.pyz = 32'(req_axis_y) * 32'(req_axis_z);
      item_in.pzz = 32'(req_axis_z) * 32'(req_axis_z);
      item_in.neg = neg;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      z_ff    <= z_in;
      item_ff <= item_in;
   end

   assign valid_s[0] = front_valid_ff;
   assign x_s[0]     = avr_pkg::GAIN_Q30;
   assign y_s[0]     = '0;
   assign z_s[0]     = z_ff;
   assign item_s[0]  = item_ff;

   // Chain of CORDIC cells, one micro-rotation each
   for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
      avr_cordic_cell #(
         .STEP(g)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .valid_i (valid_s[g]),
         .x_i     (x_s[g]),
         .y_i     (y_s[g]),
         .z_i     (z_s[g]),
         .item_i  (item_s[g]),
         .valid_o (valid_s[g+1]),
         .x_o     (x_s[g+1]),
         .y_o     (y_s[g+1]),
         .z_o     (z_s[g+1]),
         .item_o  (item_s[g+1])
      );
   end

   avr_matrix u_matrix (
      .clock   (clock),
      .reset   (reset),
      .valid_i (valid_s[CORDIC_STEPS]),
      .x_i     (x_s[CORDIC_STEPS]),
      .y_i     (y_s[CORDIC_STEPS]),
      .item_i  (item_s[CORDIC_STEPS]),
      .valid_o (mat_valid),
      .mat_o   (mat),
      .d_o     (dir),
      .e_o     (eye)
   );

   avr_apply u_apply (
      .clock   (clock),
      .reset   (reset),
      .valid_i (mat_valid),
      .mat_i   (mat),
      .d_i     (dir),
      .e_i     (eye),
      .valid_o (rsp_valid),
      .res_o   (res)
   );

   assign rsp_new_view_x = res[0];
   assign rsp_new_view_y = res[1];
   assign rsp_new_view_z = res[2];

`ifndef SYNTHESIS
   // Every result traces back to an earlier accepted request
   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept && !reset, LAT))
      else $error("result without request");

   // Every request produces its result
   a_req_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LAT rsp_valid)
      else $error("request lost");

   // Reset empties the pipeline
   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result right after reset");
`endif

endmodule

/* sim/axis_angle_view_rotate_tb.sv */
// Self-checking bench for the axis-angle view rotation: directed and random requests,
// each result compared with a bit-exact rotation predictor. Depends on the top level only.
`timescale 1ns / 1ps

module axis_angle_view_rotate_tb;

   localparam int STEPS = 16;
   localparam int CYCLE_LIMIT = 200000;

   typedef struct {
      logic signed [31:0] vx, vy, vz, ex, ey, ez;
      logic signed [15:0] ax, ay, az, ang;
   } rot_req_type;

   typedef struct {
      logic signed [31:0] nx, ny, nz;
   } view_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [31:0] req_view_x = '0, req_view_y = '0, req_view_z = '0;
   logic signed [31:0] req_eye_x = '0, req_eye_y = '0, req_eye_z = '0;
   logic signed [15:0] req_axis_x = '0, req_axis_y = '0, req_axis_z = '0;
   logic signed [15:0] req_turn_angle = '0;
   logic rsp_valid;
   logic signed [31:0] rsp_new_view_x, rsp_new_view_y, rsp_new_view_z;

   view_type expected_views[$];
   int mismatches = 0;
   int cycles = 0;

   axis_angle_view_rotate #(.CORDIC_STEPS(STEPS)) i_dut (
      .clock, .reset, .start, .busy,
      .req_view_x, .req_view_y, .req_view_z,
      .req_eye_x, .req_eye_y, .req_eye_z,
      .req_axis_x, .req_axis_y, .req_axis_z, .req_turn_angle,
      .rsp_valid, .rsp_new_view_x, .rsp_new_view_y, .rsp_new_view_z
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Arctangent of 2^-i in Q2.30
   function automatic longint arctan_step(input int i);
      longint tbl[24] = '{843314857, 497837829, 263043837, 133525159, 67021687,
         33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
         131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128};
      return tbl[i];
   endfunction

   // Round half up, then floor shift
   function automatic longint round_shift(input longint v, input int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic logic signed [31:0] clamp32(input longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   // Predict the rotated look-at point
   function automatic view_type rotated_view(input rot_req_type q);
      longint d[3], e[3], a[3], r[3][3];
      longint x, y, z, xs, ys, c, s, t, ct, a13, acc, sk;
      bit neg;
      view_type o;
      d[0] = longint'(q.vx) - q.ex; d[1] = longint'(q.vy) - q.ey;
      d[2] = longint'(q.vz) - q.ez;
      e[0] = q.ex; e[1] = q.ey; e[2] = q.ez;
      a[0] = q.ax; a[1] = q.ay; a[2] = q.az;
      a13 = q.ang;
      neg = 0;
      if (a13 > 12868) begin
         a13 -= 25736; neg = 1;
      end else if (a13 < -12868) begin
         a13 += 25736; neg = 1;
      end
      x = 652032874; y = 0; z = a13 * 131072;
      for (int i = 0; i < STEPS && i < 24; i++) begin
         xs = x >>> i; ys = y >>> i;
         if (z >= 0) begin
            x -= ys; y += xs; z -= arctan_step(i);
         end else begin
            x += ys; y -= xs; z += arctan_step(i);
         end
      end
      if (neg) begin
         x = -x; y = -y;
      end
      c = x; s = y;
      t = (64'sd1 <<< 30) - c;
      ct = round_shift(c, 6);
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            r[i][j] = round_shift(t * (a[i] * a[j]), 34);
      for (int i = 0; i < 3; i++) r[i][i] += ct;
      sk = round_shift(s * a[2], 20); r[0][1] -= sk; r[1][0] += sk;
      sk = round_shift(s * a[1], 20); r[0][2] += sk; r[2][0] -= sk;
      sk = round_shift(s * a[0], 20); r[1][2] -= sk; r[2][1] += sk;
      acc = r[0][0] * d[0] + r[0][1] * d[1] + r[0][2] * d[2];
      o.nx = clamp32(e[0] + round_shift(acc, 24));
      acc = r[1][0] * d[0] + r[1][1] * d[1] + r[1][2] * d[2];
      o.ny = clamp32(e[1] + round_shift(acc, 24));
      acc = r[2][0] * d[0] + r[2][1] * d[1] + r[2][2] * d[2];
      o.nz = clamp32(e[2] + round_shift(acc, 24));
      return o;
   endfunction

   // Check each result against the oldest prediction
   always @(posedge clock) begin
      view_type w;
      cycles <= cycles + 1;
      if (!reset && rsp_valid) begin
         if (expected_views.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %0d %0d %0d",
               rsp_new_view_x, rsp_new_view_y, rsp_new_view_z);
         end else begin
            w = expected_views.pop_front();
            if (w.nx !== rsp_new_view_x || w.ny !== rsp_new_view_y ||
                w.nz !== rsp_new_view_z) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                     w.nx, w.ny, w.nz, rsp_new_view_x, rsp_new_view_y, rsp_new_view_z);
            end
         end
      end
   end

   // Hold the request until taken, then, if gaps are asked for, drop start for a random gap
   task automatic send_request(input rot_req_type q, input bit gaps);
      int gap;
      req_view_x <= q.vx; req_view_y <= q.vy; req_view_z <= q.vz;
      req_eye_x <= q.ex; req_eye_y <= q.ey; req_eye_z <= q.ez;
      req_axis_x <= q.ax; req_axis_y <= q.ay; req_axis_z <= q.az;
      req_turn_angle <= q.ang;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      expected_views.push_back(rotated_view(q));
      gap = gaps ? $urandom_range(0, 14) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic rot_req_type random_request();
      rot_req_type q;
      q.vx = $urandom; q.vy = $urandom; q.vz = $urandom;
      q.ex = $urandom; q.ey = $urandom; q.ez = $urandom;
      // Mostly unit-range axes and in-range angles, some full-width noise
      if ($urandom_range(0, 9) == 0) begin
         q.ax = 16'($urandom); q.ay = 16'($urandom); q.az = 16'($urandom);
         q.ang = 16'($urandom);
      end else begin
         q.ax = 16'($urandom_range(0, 32768) - 16384);
         q.ay = 16'($urandom_range(0, 32768) - 16384);
         q.az = 16'($urandom_range(0, 32768) - 16384);
         q.ang = 16'($urandom_range(0, 51472) - 25736);
      end
      // Small coordinates often, so results are not all saturated
      if ($urandom_range(0, 1)) begin
         q.vx = q.vx >>> 12; q.vy = q.vy >>> 12; q.vz = q.vz >>> 12;
         q.ex = q.ex >>> 12; q.ey = q.ey >>> 12; q.ez = q.ez >>> 12;
      end
      return q;
   endfunction

   task automatic test_directed();
      rot_req_type q;
      logic signed [15:0] angs[12] = '{16'sd0, 16'sd12868, -16'sd12868, 16'sd12869,
         -16'sd12869, 16'sd25736, -16'sd25736, 16'sd6434, 16'sh7fff, 16'sh8000,
         16'sd1, -16'sd1};
      foreach (angs[k]) begin
         q.vx = 32'sd65536 * (k + 1); q.vy = -32'sd131072; q.vz = 32'sd32768;
         q.ex = 32'sd0; q.ey = 32'sd65536; q.ez = -32'sd65536;
         q.ax = (k % 3 == 0) ? 16'sd16384 : 16'sd0;
         q.ay = (k % 3 == 1) ? -16'sd16384 : 16'sd0;
         q.az = (k % 3 == 2) ? 16'sd16384 : 16'sd0;
         q.ang = angs[k];
         send_request(q, k[0]);
      end
      // Field extremes, non-unit axes and saturation both ways
      q.vx = 32'sh7fffffff; q.vy = 32'sh80000000; q.vz = 32'sh7fffffff;
      q.ex = 32'sh80000000; q.ey = 32'sh7fffffff; q.ez = 32'sh80000000;
      q.ax = 16'sh7fff; q.ay = 16'sh8000; q.az = 16'sd16384; q.ang = 16'sd25736;
      send_request(q, 0);
      q.ax = 16'sd0; q.ay = 16'sd0; q.az = 16'sd0; q.ang = 16'sd100;
      send_request(q, 0);
      q.vx = 32'sh80000000; q.vy = 32'sh7fffffff; q.vz = 32'sh80000000;
      q.ex = 32'sh7fffffff; q.ey = 32'sh80000000; q.ez = 32'sh7fffffff;
      q.ax = -16'sd16384; q.ay = 16'sd16384; q.az = -16'sd16384; q.ang = -16'sd25736;
      send_request(q, 1);
      q.ax = 16'sd9459; q.ay = 16'sd9459; q.az = 16'sd9459; q.ang = 16'sd8579;
      q.vx = -1; q.vy = 0; q.vz = 1; q.ex = 0; q.ey = -1; q.ez = 1;
      send_request(q, 0);
   endtask

   task automatic test_random();
      for (int n = 0; n < 1300; n++)
         send_request(random_request(), (n / 100) % 3 != 0);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random();
      start <= 1'b0;
      while (expected_views.size() != 0) @(posedge clock);
      repeat (STEPS + 20) @(posedge clock);
      if (mismatches == 0 && expected_views.size() == 0)
         $display("axis_angle_view_rotate_tb passed");
      else
         $display("axis_angle_view_rotate_tb failed");
      $finish;
   end

   // Give up on a hang
   always @(posedge clock) begin
      if (cycles >= CYCLE_LIMIT) begin
         $display("axis_angle_view_rotate_tb failed");
         $finish;
      end
   end

endmodule

/* sim.f */
hdl/avr_pkg.sv
hdl/avr_cordic_cell.sv
hdl/avr_matrix.sv
hdl/avr_apply.sv
hdl/axis_angle_view_rotate.sv
sim/axis_angle_view_rotate_tb.sv
